### rtl/fmse_pkg.sv
// ----------------------------------------------------------------------------
// fmse_pkg
// Shared widths, codes, constants, tables and control/status bundles of the
// first-zero sketch estimator.
// ----------------------------------------------------------------------------
package fmse_pkg;

    // Item fields
    localparam int NODE_W   = 12;
    localparam int VEC_W    = 64;
    localparam int CNT_W    = 7;
    localparam int EST_W    = 64;
    localparam int SUM_W    = 16;
    localparam int ROUNDS_W = 10;

    // Sum store
    localparam int NODES    = 4096;
    localparam int NODE_AW  = $clog2(NODES);

    // Operation codes
    localparam logic OP_ACC = 1'b0;
    localparam logic OP_EST = 1'b1;

    // Register map: register select is paddr[2]
    localparam int   PADDR_W    = 3;
    localparam logic REG_WIDE   = 1'b0;
    localparam logic REG_ROUNDS = 1'b1;

    // Estimate arithmetic
    localparam int QUO_W     = SUM_W + 8;         // Q.8 mean
    localparam int DIV_STEPS = QUO_W;             // one quotient bit per step
    localparam int MUL_STEPS = 9;                 // eight root steps, then 1/c
    localparam int STEP_W    = 5;
    localparam int M_W       = 32;
    localparam int COEF_W    = 31;

    localparam logic [COEF_W-1:0] ONE_Q30   = 31'd1073741824;
    localparam logic [COEF_W-1:0] INV_C_Q30 = 31'd1388142135;

    // 2^(2^(k-8)) in Q30, k = 0 .. 7
    function automatic logic [COEF_W-1:0] f_root_q30(input logic [2:0] k);
        logic [COEF_W-1:0] r;
        begin
            case (k)
                3'd0:    r = 31'd1076653033;
                3'd1:    r = 31'd1079572136;
                3'd2:    r = 31'd1085434106;
                3'd3:    r = 31'd1097253708;
                3'd4:    r = 31'd1121280436;
                3'd5:    r = 31'd1170923762;
                3'd6:    r = 31'd1276901417;
                default: r = 31'd1518500250;
            endcase
            return r;
        end
    endfunction

    // Controller -> datapath
    typedef struct packed {
        logic       cap_in;     // input word accepted, start read of its sum
        logic       acc_wr;     // write back saturated sum
        logic       est_ld;     // load dividend, clear the sum
        logic       div_step;   // one restoring-division step
        logic       mul_step;   // one mantissa multiply
        logic [3:0] mul_idx;    // which multiply step
        logic       fin;        // final shift and saturation
        logic       load_out;   // move result into output register
        logic       clr_step;   // clearing pass, one entry
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic clr_last;
    } t_sts;

endpackage

### rtl/fmse_in_if.sv
// ----------------------------------------------------------------------------
// fmse_in_if
// Input channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface fmse_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [fmse_pkg::NODE_W-1:0]  node;
    logic [fmse_pkg::VEC_W-1:0]   bit_vector;

    modport source (output valid, output op, output node, output bit_vector, input ready);
    modport sink   (input valid, input op, input node, input bit_vector, output ready);
endinterface

### rtl/fmse_out_if.sv
// ----------------------------------------------------------------------------
// fmse_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface fmse_out_if;
    logic                        valid;
    logic                        ready;
    logic [fmse_pkg::CNT_W-1:0]  run_len;
    logic [fmse_pkg::EST_W-1:0]  estimate;
    logic                        saturated;

    modport source (output valid, output run_len, output estimate, output saturated,
                    input ready);
    modport sink   (input valid, input run_len, input estimate, input saturated,
                    output ready);
endinterface

### rtl/fmse_ram.sv
// ----------------------------------------------------------------------------
// fmse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fmse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/fmse_dp.sv
// ----------------------------------------------------------------------------
// fmse_dp
// Datapath: sum store, trailing-ones count, restoring divider, mantissa
// multiplier, final shifter and output register.
// ----------------------------------------------------------------------------
module fmse_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fmse_pkg::t_cmd                 i_cmd,
    output fmse_pkg::t_sts                 o_sts,
    input  logic                           i_wide,
    input  logic [fmse_pkg::ROUNDS_W-1:0]  i_rounds,
    input  logic                           i_op,
    input  logic [fmse_pkg::NODE_W-1:0]    i_node,
    input  logic [fmse_pkg::VEC_W-1:0]     i_bit_vector,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [fmse_pkg::CNT_W-1:0]     o_run_len,
    output logic [fmse_pkg::EST_W-1:0]     o_estimate,
    output logic                           o_saturated
);

    localparam int AW = fmse_pkg::NODE_AW;

    function automatic logic [fmse_pkg::CNT_W-1:0] f_trailing_ones(
        input logic [fmse_pkg::VEC_W-1:0] v);
        logic [fmse_pkg::CNT_W-1:0] n;
        begin
            n = fmse_pkg::CNT_W'(fmse_pkg::VEC_W);
            for (int i = fmse_pkg::VEC_W - 1; i >= 0; i--) begin
                if (!v[i]) begin
                    n = fmse_pkg::CNT_W'(i);
                end
            end
            return n;
        end
    endfunction

    // Captured word
    logic                           r_op;
    logic [fmse_pkg::NODE_W-1:0]    r_node;
    logic [fmse_pkg::CNT_W-1:0]     r_cnt;

    // Estimate datapath
    logic [fmse_pkg::QUO_W-1:0]     r_quo;
    logic [fmse_pkg::ROUNDS_W-1:0]  r_rem;
    logic [fmse_pkg::M_W-1:0]       r_m;
    logic [fmse_pkg::EST_W-1:0]     r_est;
    logic                           r_sat;

    // Clearing pass, output register
    logic [AW-1:0]                  r_clr_addr;
    logic                           r_out_valid;
    logic [fmse_pkg::CNT_W-1:0]     r_out_fz;
    logic [fmse_pkg::EST_W-1:0]     r_out_est;
    logic                           r_out_sat;

    logic [fmse_pkg::VEC_W-1:0]     vec_eff;
    logic [fmse_pkg::CNT_W-1:0]     cnt;
    logic                           node_ok;
    logic [fmse_pkg::SUM_W-1:0]     rd_data;
    logic [fmse_pkg::SUM_W-1:0]     sum_rd;
    logic [fmse_pkg::SUM_W:0]       sum_add;
    logic [fmse_pkg::SUM_W-1:0]     sum_sat;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [fmse_pkg::SUM_W-1:0]     wr_data;

    logic [fmse_pkg::ROUNDS_W-1:0]  divisor;
    logic [fmse_pkg::ROUNDS_W:0]    rem_sh;
    logic                           rem_ge;
    logic [fmse_pkg::ROUNDS_W:0]    rem_nx;

    logic [2:0]                     root_k;
    logic [fmse_pkg::COEF_W-1:0]    coef;
    logic [fmse_pkg::M_W+fmse_pkg::COEF_W-1:0] prod;

    logic [fmse_pkg::SUM_W-1:0]     ipart;
    logic [fmse_pkg::SUM_W-1:0]     sh_amt;
    logic [95:0]                    up_wide;
    logic [fmse_pkg::EST_W-1:0]     est_nx;
    logic                           sat_nx;

    // In narrow mode the upper half is forced to zero, capping the count at 32
    assign vec_eff = i_wide ? i_bit_vector : {32'h0, i_bit_vector[31:0]};
    assign cnt     = f_trailing_ones(vec_eff);
    assign node_ok = ({1'b0, r_node} < (fmse_pkg::NODE_W + 1)'(fmse_pkg::NODES));

    fmse_ram #(
        .WIDTH (fmse_pkg::SUM_W),
        .DEPTH (fmse_pkg::NODES)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.cap_in),
        .i_rd_addr (i_node[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign sum_rd  = node_ok ? rd_data : '0;
    assign sum_add = {1'b0, sum_rd} + (fmse_pkg::SUM_W + 1)'(r_cnt);
    assign sum_sat = sum_add[fmse_pkg::SUM_W] ? '1 : sum_add[fmse_pkg::SUM_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node[AW-1:0];
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
        end else if (i_cmd.acc_wr) begin
            wr_en   = node_ok;
            wr_data = sum_sat;
        end else if (i_cmd.est_ld) begin
            wr_en   = node_ok;
        end
    end

    // Restoring division, one quotient bit per step; rounds of zero acts as one
    assign divisor = (i_rounds == '0) ? fmse_pkg::ROUNDS_W'(1) : i_rounds;
    assign rem_sh  = {r_rem, r_quo[fmse_pkg::QUO_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, divisor});
    assign rem_nx  = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;

    // Mantissa steps: fraction bits 7 down to 0, then 1/c
    assign root_k = 3'd7 - i_cmd.mul_idx[2:0];
    always_comb begin
        if (i_cmd.mul_idx[3]) begin
            coef = fmse_pkg::INV_C_Q30;
        end else if (r_quo[root_k]) begin
            coef = fmse_pkg::f_root_q30(root_k);
        end else begin
            coef = fmse_pkg::ONE_Q30;
        end
    end
    assign prod = r_m * coef;

    // Scale by 2^ipart / 2^22 with saturation
    assign ipart = r_quo[fmse_pkg::QUO_W-1:8];
    always_comb begin
        sh_amt  = '0;
        up_wide = '0;
        est_nx  = '0;
        sat_nx  = 1'b0;
        if (ipart < 16'd22) begin
            sh_amt = 16'd22 - ipart;
            est_nx = {32'h0, r_m} >> sh_amt[4:0];
        end else begin
            sh_amt  = ipart - 16'd22;
            up_wide = {64'h0, r_m} << sh_amt[5:0];
            if ((sh_amt >= 16'd64) || (up_wide[95:64] != '0)) begin
                sat_nx = 1'b1;
                est_nx = '1;
            end else begin
                est_nx = up_wide[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op   <= i_op;
            r_node <= i_node;
            r_cnt  <= cnt;
        end
        if (i_cmd.est_ld) begin
            r_quo <= {sum_rd, 8'h0};
            r_rem <= '0;
            r_m   <= fmse_pkg::M_W'(fmse_pkg::ONE_Q30);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[fmse_pkg::QUO_W-2:0], rem_ge};
            r_rem <= rem_nx[fmse_pkg::ROUNDS_W-1:0];
        end
        if (i_cmd.mul_step) begin
            r_m <= prod[61:30];
        end
        if (i_cmd.fin) begin
            r_est <= est_nx;
            r_sat <= sat_nx;
        end
        if (i_cmd.load_out) begin
            r_out_fz  <= (r_op == fmse_pkg::OP_ACC) ? r_cnt : '0;
            r_out_est <= (r_op == fmse_pkg::OP_ACC) ? '0 : r_est;
            r_out_sat <= (r_op == fmse_pkg::OP_ACC) ? 1'b0 : r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.clr_last = (r_clr_addr == AW'(fmse_pkg::NODES - 1));

    assign o_out_valid  = r_out_valid;
    assign o_run_len    = r_out_fz;
    assign o_estimate   = r_out_est;
    assign o_saturated  = r_out_sat;

endmodule

### rtl/fmse_ctrl.sv
// ----------------------------------------------------------------------------
// fmse_ctrl
// Sequencer: clearing pass, word intake, accumulate write-back, divide and
// multiply step counting, result hand-off.
// ----------------------------------------------------------------------------
module fmse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_ready,
    input  fmse_pkg::t_sts i_sts,
    output fmse_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_EST_RD = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [fmse_pkg::STEP_W-1:0] DIV_LAST =
        fmse_pkg::STEP_W'(fmse_pkg::DIV_STEPS - 1);
    localparam logic [fmse_pkg::STEP_W-1:0] MUL_LAST =
        fmse_pkg::STEP_W'(fmse_pkg::MUL_STEPS - 1);

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [fmse_pkg::STEP_W-1:0] r_step;
    logic [fmse_pkg::STEP_W-1:0] n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_idx = r_step[3:0];
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state = (i_in_op == fmse_pkg::OP_EST) ? S_EST_RD : S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_wr = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EST_RD: begin
                o_cmd.est_ld = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_step  = '0;
                    n_state = S_MUL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == MUL_LAST) begin
                    n_step  = '0;
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### rtl/fm_sketch_first_zero_estimator.sv
// ----------------------------------------------------------------------------
// fm_sketch_first_zero_estimator
// Per-node first-zero sketch accumulator and 2^mean / 0.77351 estimator.
// ----------------------------------------------------------------------------
// Usage:
//  - i_in carries request words: op 0 accumulates a node's sketch vector,
//    op 1 reads that node's estimate and clears its sum. o_out returns exactly
//    one result word per request, in order.
//  - Accumulate: trailing ones (32- or 64-bit view) are added to the node's
//    16-bit sum, saturating. The result is loaded with the sum RAM write-back
//    (or later, if the output register is full) before the next word is taken.
//  - Estimate: a 24-step restoring divider (sum * 256 / rounds), nine
//    multiply steps on the Q30 mantissa and a final shift give a Q56.8 value.
//    Read, divide, multiply and final states run, then the result is loaded
//    once the output register is free; the next word is taken back in idle.
//  - The output register holds a finished word while a new request is
//    accepted. When the receiver stalls, the block finishes the current
//    request and then waits with ready low until the register frees up.
//  - After reset the sum RAM is cleared one entry per cycle, all 4096 entries,
//    with ready low. Config writes are taken at any time.
//  - APB registers: 0x0 wide_vectors (1 bit), 0x4 rounds (10 bits, 0 acts
//    as 1). Write only while idle.
// ----------------------------------------------------------------------------
module fm_sketch_first_zero_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fmse_in_if.sink                       i_in,
    fmse_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmse_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Config registers
    logic                           r_wide;
    logic [fmse_pkg::ROUNDS_W-1:0]  r_rounds;
    logic                           cfg_wr;
    logic                           reg_sel;

    fmse_pkg::t_cmd cmd;
    fmse_pkg::t_sts sts;
    logic           in_ready;

    // APB: zero wait states, register picked by paddr[2]
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide   <= 1'b0;
            r_rounds <= fmse_pkg::ROUNDS_W'(1);
        end else if (cfg_wr) begin
            if (reg_sel == fmse_pkg::REG_WIDE) begin
                r_wide <= pwdata[0];
            end else begin
                r_rounds <= pwdata[fmse_pkg::ROUNDS_W-1:0];
            end
        end
    end

    always_comb begin
        case (reg_sel)
            fmse_pkg::REG_WIDE:   prdata = {31'h0, r_wide};
            fmse_pkg::REG_ROUNDS: prdata = {22'h0, r_rounds};
            default:              prdata = '0;
        endcase
    end

    // Sequencer
    fmse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Sum store, arithmetic and output word register
    fmse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_wide       (r_wide),
        .i_rounds     (r_rounds),
        .i_op         (i_in.op),
        .i_node       (i_in.node),
        .i_bit_vector (i_in.bit_vector),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_run_len    (o_out.run_len),
        .o_estimate   (o_out.estimate),
        .o_saturated  (o_out.saturated)
    );

endmodule

### tb/sv/fmse_sketch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fmse_sketch_checker
// Passive checker for the first-zero sketch estimator. It snoops the request
// and result channels and the APB writes, keeps its own copy of the per-node
// sums and the registers, predicts every result word and compares it in order.
// ----------------------------------------------------------------------------
module fmse_sketch_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fmse_in_if                            i_req,
    fmse_out_if                           i_rsp,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [fmse_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_count_words,
    output int                            o_est_words,
    output int                            o_clamped_words
);
    import fmse_pkg::*;

    localparam logic [63:0] MANT_ONE     = 64'd1073741824;   // 1.0 in Q30
    localparam logic [31:0] INV_GAIN_Q30 = 32'd1388142135;   // 1 / 0.77351

    typedef struct packed {
        logic              op;
        logic [CNT_W-1:0]  run_len;
        logic [EST_W-1:0]  estimate;
        logic              saturated;
    } t_sketch_result;

    t_sketch_result       expected_words[$];
    logic [SUM_W-1:0]     node_sums[NODES];
    logic                 wide_mode;
    logic [ROUNDS_W-1:0]  rounds_cfg;
    int                   fails, acc_seen, est_seen, clamp_seen;

    // 2^(2^(k-8)) in Q30
    function automatic logic [31:0] root_step(input logic [2:0] k);
        begin
            case (k)
                3'd0:    return 32'd1076653033;
                3'd1:    return 32'd1079572136;
                3'd2:    return 32'd1085434106;
                3'd3:    return 32'd1097253708;
                3'd4:    return 32'd1121280436;
                3'd5:    return 32'd1170923762;
                3'd6:    return 32'd1276901417;
                default: return 32'd1518500250;
            endcase
        end
    endfunction

    // trailing ones within the active vector width
    function automatic logic [CNT_W-1:0] ones_run(input logic [VEC_W-1:0] vec,
                                                  input logic wide);
        int   lim;
        int   n;
        logic open;
        begin
            lim  = wide ? 64 : 32;
            n    = 0;
            open = 1'b1;
            for (int b = 0; b < VEC_W; b++) begin
                if (open && b < lim && vec[b])
                    n++;
                else
                    open = 1'b0;
            end
            return CNT_W'(n);
        end
    endfunction

    // {saturated, Q56.8 estimate} of 2^(sum/rounds) / 0.77351
    function automatic logic [EST_W:0] sketch_estimate(input logic [SUM_W-1:0] sum,
                                                       input logic [ROUNDS_W-1:0] div);
        logic [31:0] dividend, divisor, mean;
        logic [63:0] mant;
        int          ipart, shl;
        begin
            dividend = {8'd0, sum, 8'd0};
            divisor  = (div == '0) ? 32'd1 : {22'd0, div};
            mean     = dividend / divisor;
            ipart    = mean[23:8];
            mant     = MANT_ONE;
            for (int k = 7; k >= 0; k--) begin
                if (mean[k])
                    mant = (mant * root_step(3'(k))) >> 30;
            end
            mant = (mant * INV_GAIN_Q30) >> 30;
            if (ipart < 22)
                return {1'b0, mant >> (22 - ipart)};
            shl = ipart - 22;
            if (shl == 0)
                return {1'b0, mant};
            if (shl >= 64 || (mant >> (64 - shl)) != 64'd0)
                return {1'b1, {EST_W{1'b1}}};
            return {1'b0, mant << shl};
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_sketch_result     exp_w;
        logic [EST_W:0]     est_pair;
        logic [SUM_W-1:0]   sum_now;
        logic [SUM_W:0]     sum_next;
        logic               bad;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++)
                node_sums[i] = '0;
            expected_words.delete();
            wide_mode  = 1'b0;
            rounds_cfg = 10'd1;
            fails      = 0;
            acc_seen   = 0;
            est_seen   = 0;
            clamp_seen = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_WIDE)
                    wide_mode = i_pwdata[0];
                else
                    rounds_cfg = i_pwdata[ROUNDS_W-1:0];
            end

            // node is 12 bits wide, so every index is inside the store
            if (i_req.valid && i_req.ready) begin
                exp_w    = '0;
                exp_w.op = i_req.op;
                sum_now  = node_sums[i_req.node];
                if (i_req.op == OP_ACC) begin
                    exp_w.run_len = ones_run(i_req.bit_vector, wide_mode);
                    sum_next = sum_now + exp_w.run_len;
                    node_sums[i_req.node] = sum_next[SUM_W] ? {SUM_W{1'b1}}
                                                            : sum_next[SUM_W-1:0];
                end else begin
                    est_pair = sketch_estimate(sum_now, rounds_cfg);
                    exp_w.saturated = est_pair[EST_W];
                    exp_w.estimate  = est_pair[EST_W-1:0];
                    node_sums[i_req.node] = '0;
                end
                expected_words.push_back(exp_w);
            end

            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected (run %0d est %h sat %b)",
                             $time, i_rsp.run_len, i_rsp.estimate, i_rsp.saturated);
                    fails++;
                end else begin
                    exp_w = expected_words.pop_front();
                    bad   = 1'b0;
                    if (i_rsp.run_len !== exp_w.run_len) begin
                        $display("%0t: run_len expected %0d actual %0d",
                                 $time, exp_w.run_len, i_rsp.run_len);
                        bad = 1'b1;
                    end
                    if (i_rsp.estimate !== exp_w.estimate) begin
                        $display("%0t: estimate expected %h actual %h",
                                 $time, exp_w.estimate, i_rsp.estimate);
                        bad = 1'b1;
                    end
                    if (i_rsp.saturated !== exp_w.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_w.saturated, i_rsp.saturated);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                    if (exp_w.op == OP_ACC)
                        acc_seen++;
                    else
                        est_seen++;
                    if (exp_w.saturated)
                        clamp_seen++;
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_words.size();
        o_count_words   <= acc_seen;
        o_est_words     <= est_seen;
        o_clamped_words <= clamp_seen;
    end

endmodule

### tb/sv/fm_sketch_first_zero_estimator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fm_sketch_first_zero_estimator_test
// Top of the estimator regression. Drives request words, APB register writes
// and the result-side ready; the checker beside the block predicts and
// compares every result word. Directed corner words come first, then random
// phases over several register settings, with a long sum-clamp sweep among them.
// ----------------------------------------------------------------------------
module fm_sketch_first_zero_estimator_test;
    import fmse_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata, prdata;

    fmse_in_if  req_ch ();
    fmse_out_if rsp_ch ();

    // idling knobs, in percent of cycles
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    // receiver hold-off request: bump hold_tag to start a stall, its length set by hold_len
    int hold_len      = 0;
    int hold_tag      = 0;
    int words_sent    = 0;

    int fail_count, pending, count_words, est_words, clamped_words;

    fm_sketch_first_zero_estimator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fmse_sketch_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_count_words   (count_words),
        .o_est_words     (est_words),
        .o_clamped_words (clamped_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, or a long hold-off when the stimulus asks.
    initial begin : receiver
        int hold_seen, hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tag != hold_seen) begin
                hold_seen = hold_tag;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Offer one request word, with random idle cycles ahead of it, and return
    // at the edge where it is taken. valid stays high so back-to-back words
    // go out with no bubble.
    task automatic offer_word(input logic op, input logic [NODE_W-1:0] node,
                              input logic [VEC_W-1:0] vec);
        begin
            while ($urandom_range(99) < snd_idle_pct) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            req_ch.valid      <= 1'b1;
            req_ch.op         <= op;
            req_ch.node       <= node;
            req_ch.bit_vector <= vec;
            @(posedge i_clk);
            while (!req_ch.ready)
                @(posedge i_clk);
            words_sent++;
        end
    endtask

    // Stop offering and wait for every outstanding result word. The first
    // edge lets the checker's count settle after the last acceptance.
    task automatic drain;
        begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            wait (pending == 0);
            @(posedge i_clk);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic sel, input logic [31:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {sel, 2'b00};
            pwdata  <= value;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready)
                @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Registers only change with the block idle.
    task automatic configure(input logic wide, input logic [ROUNDS_W-1:0] rounds);
        begin
            drain();
            write_reg(REG_WIDE, {31'd0, wide});
            write_reg(REG_ROUNDS, {22'd0, rounds});
        end
    endtask

    // Random request word. Most nodes come from a small pool so sums build up
    // and estimates see real values; the rest land anywhere in the store.
    // Most vectors are shaped to a random run of trailing ones (0..64) with
    // random bits above the first zero; the rest are raw random or all ones.
    task automatic random_word(input int unsigned pool_base);
        logic              op;
        logic [NODE_W-1:0] node;
        logic [VEC_W-1:0]  vec;
        int unsigned       n;
        begin
            op = ($urandom_range(99) < 15) ? OP_EST : OP_ACC;
            if ($urandom_range(99) < 85)
                node = NODE_W'(pool_base + $urandom_range(7));
            else
                node = NODE_W'($urandom_range(NODES - 1));
            vec = {$urandom, $urandom};
            if ($urandom_range(99) < 70) begin
                n = $urandom_range(64);
                for (int b = 0; b < VEC_W; b++) begin
                    if (b < n)
                        vec[b] = 1'b1;
                    else if (b == n)
                        vec[b] = 1'b0;
                end
            end else if ($urandom_range(99) < 10) begin
                vec = '1;
            end
            offer_word(op, node, vec);
        end
    endtask

    initial begin : stimulus
        int unsigned rnd_rounds;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_ACC;
        req_ch.node       <= '0;
        req_ch.bit_vector <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: sender idles lightly, receiver stalls half the time ---
        snd_idle_pct  = 10;
        rcv_stall_pct = 50;
        configure(1'b0, 10'd1);

        // 32-bit view: empty, full, upper half ignored, alternating patterns
        offer_word(OP_ACC, 12'd0,    64'h0000_0000_0000_0000);
        offer_word(OP_ACC, 12'd0,    64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(OP_ACC, 12'd0,    64'h0000_0001_FFFF_FFFF);
        offer_word(OP_ACC, 12'd4095, 64'hFFFF_FFFF_0000_0000);
        offer_word(OP_ACC, 12'd4095, 64'h5555_5555_5555_5555);
        offer_word(OP_ACC, 12'd4095, 64'h0000_0000_7FFF_FFFF);
        offer_word(OP_ACC, 12'd4095, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_word(OP_ACC, 12'd9,    64'h0000_0000_003F_FFFF);
        // sum 64 at one round: estimate overflows and clamps
        offer_word(OP_EST, 12'd0,    64'hFFFF_FFFF_FFFF_FFFF);
        // sum was cleared by the estimate: plain 1/c, shifted right
        offer_word(OP_EST, 12'd0,    64'h0);
        // sum 32: left shift by 10
        offer_word(OP_EST, 12'd4095, 64'h0);
        // mean of exactly 22: mantissa passes unshifted
        offer_word(OP_EST, 12'd9,    64'h0);
        offer_word(OP_EST, 12'd100,  64'h0);

        // 64-bit view, widest divisor
        configure(1'b1, 10'd1023);
        offer_word(OP_ACC, 12'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(OP_ACC, 12'd1, 64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(OP_ACC, 12'd1, 64'h0000_0000_FFFF_FFFF);
        offer_word(OP_ACC, 12'd2, 64'h8000_0000_0000_0000);
        offer_word(OP_EST, 12'd1, 64'h0);
        offer_word(OP_EST, 12'd2, 64'h0);

        // a round count of zero divides as one
        configure(1'b1, 10'd0);
        offer_word(OP_ACC, 12'd3, 64'h0000_0000_0000_00FF);
        offer_word(OP_EST, 12'd3, 64'h0);

        // --- random, still sender 10 / receiver 50 ---
        configure(1'b0, 10'd3);
        repeat (100) random_word(16);
        configure(1'b1, 10'd1023);
        repeat (100) random_word(32);

        // --- sender 50 / receiver 10 ---
        snd_idle_pct  = 50;
        rcv_stall_pct = 10;

        // Sum clamp: 1030 full 64-bit runs push node 4095 past 65535. With
        // 1023 rounds a held sum gives a mean of 64 and a clamped estimate;
        // a wrapped sum would give a small one.
        configure(1'b1, 10'd1023);
        repeat (1030) offer_word(OP_ACC, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(OP_EST, 12'd4095, 64'h0);
        offer_word(OP_ACC, 12'd4095, 64'h0000_0000_0000_000F);
        offer_word(OP_EST, 12'd4095, 64'h0);

        configure(1'b1, 10'd0);
        repeat (100) random_word(48);

        // --- no idling on either side ---
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;

        rnd_rounds = $urandom_range(1023, 2);
        configure(1'b0, ROUNDS_W'(rnd_rounds));
        repeat (50) random_word(64);
        // sender pauses until every result is back, then carries on
        drain();
        repeat (50) random_word(64);

        // receiver holds off while words keep coming, so the output register fills
        // and the block drops its input ready
        rnd_rounds = $urandom_range(40, 1);
        configure(1'b1, ROUNDS_W'(rnd_rounds));
        hold_len = 400;
        hold_tag = hold_tag + 1;
        repeat (40) offer_word(OP_ACC, 12'd7, {$urandom, $urandom});
        repeat (60) random_word(80);

        configure(1'b0, 10'd1);
        repeat (100) random_word(96);

        // let the estimate pipeline settle well past its latency
        drain();
        repeat (60) @(posedge i_clk);

        $display("Sent %0d words; checked %0d counts and %0d estimates (%0d clamped).",
                 words_sent, count_words, est_words, clamped_words);
        $display("Covered 32/64-bit views, rounds 0/1/1023/random, sum clamp, hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run, clearing pass included
    initial begin
        #4_000_000;
        $display("Timeout with %0d result words outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
